### rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg: shared types and codes for the alarm clock controller
// Item layouts, state and mode codes, configuration indexes.
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MUTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE    = 1'd1;

	localparam logic [15:0] AUTO_MUTE_RST = 16'd60;
	localparam logic [15:0] SNOOZE_RST    = 16'd300;

	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_SET    = 3'd1;
	localparam logic [2:0] MODE_TOGGLE = 3'd2;
	localparam logic [2:0] MODE_SNOOZE = 3'd3;
	localparam logic [2:0] MODE_MUTE   = 3'd4;

	localparam logic [1:0] ST_DISABLED = 2'd0;
	localparam logic [1:0] ST_ENABLED  = 2'd1;
	localparam logic [1:0] ST_ACTIVE   = 2'd2;
	localparam logic [1:0] ST_SNOOZED  = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] now_seconds;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [4:0]  set_hour;
		logic [5:0]  set_minute;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] alarm_state;
		logic       buzzing;
		logic       buzzer_start;
		logic [4:0] alarm_hour_out;
		logic [5:0] alarm_minute_out;
	} result_item_t;

	typedef struct packed {
		logic [15:0] auto_mute_seconds;
		logic [15:0] snooze_seconds;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode_state;
		logic [4:0]  alarm_hour;
		logic [5:0]  alarm_minute;
		logic [31:0] activated_at;
		logic [31:0] snooze_deadline;
		logic [5:0]  last_fired_minute;
		logic        last_fired_valid;
	} alarm_st_t;

endpackage

### rtl/acc_if.sv
// ----------------------------------------------------------------------------
// acc_if: item channels of the alarm clock controller
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface acc_cmd_if;
	logic               valid;
	logic               ready;
	acc_pkg::cmd_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface acc_result_if;
	logic                  valid;
	logic                  ready;
	acc_pkg::result_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/alarm_clock_controller_core.sv
// ----------------------------------------------------------------------------
// alarm_clock_controller_core: alarm clock controller with snooze
// Input register, next-state logic, alarm state and result register.
// ----------------------------------------------------------------------------
// Takes one command item per cycle while results are taken, and returns one
// result item per command. An item is captured in an input register and applied
// to the alarm state once the result register is free or being read, with its
// result registered at the end of that cycle; the state update is combinational,
// so the input register takes a new item in the cycle it hands one on.
// The result register lets a new item enter while a result waits. Write the
// auto-mute and snooze durations only while no item is in flight.
module alarm_clock_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	acc_cmd_if.sink                        cmd,
	acc_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [acc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import acc_pkg::*;

	cfg_t         cfg;
	cmd_item_t    item_s1;
	logic         valid_s1;
	alarm_st_t    st_q;
	alarm_st_t    st_nxt;
	result_item_t res_nxt;
	result_item_t res_q;
	logic         res_valid_q;
	logic         advance;

	acc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	acc_step u_step (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	assign advance   = valid_s1 && (!res_valid_q || result.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			st_q        <= st_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_buzzer_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.buzzer_start |->
			(result.data.alarm_state == ST_ACTIVE || result.data.alarm_state == ST_ENABLED))
		else $error("buzzer start reported without the alarm firing");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("alarm state changed without an item");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid && result.data.alarm_state == $past(st_nxt.mode_state))
		else $error("result lost or wrong after an item advanced");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("waiting result changed");

endmodule

### rtl/acc_cfg.sv
// ----------------------------------------------------------------------------
// acc_cfg: configuration registers
// Auto-mute and snooze durations, written through a plain write port.
// ----------------------------------------------------------------------------
module acc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [acc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output acc_pkg::cfg_t                   cfg
);
	import acc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_mute_seconds <= AUTO_MUTE_RST;
			cfg_q.snooze_seconds    <= SNOOZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AUTO_MUTE: cfg_q.auto_mute_seconds <= cfg_wdata;
				CFG_SNOOZE:    cfg_q.snooze_seconds    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/acc_step.sv
// ----------------------------------------------------------------------------
// acc_step: alarm next-state logic
// Applies one command item to the alarm state and forms its result.
// ----------------------------------------------------------------------------
module acc_step (
	input  acc_pkg::cmd_item_t    item,
	input  acc_pkg::alarm_st_t    st,
	input  acc_pkg::cfg_t         cfg,
	output acc_pkg::alarm_st_t    st_nxt,
	output acc_pkg::result_item_t res
);
	import acc_pkg::*;

	logic        fire;
	logic        start;
	logic [31:0] since_act;
	logic [31:0] past_deadline;
	logic        mute_due;
	logic [31:0] snooze_end;

	assign fire = (st.mode_state == ST_ENABLED) &&
		(item.now_hour == st.alarm_hour) && (item.now_minute == st.alarm_minute) &&
		(!st.last_fired_valid || (st.last_fired_minute != item.now_minute));

	assign since_act     = item.now_seconds - st.activated_at;
	assign past_deadline = item.now_seconds - st.snooze_deadline;
	assign mute_due      = since_act >= {16'd0, cfg.auto_mute_seconds};
	assign snooze_end    = item.now_seconds + {16'd0, cfg.snooze_seconds};

	always_comb begin
		st_nxt = st;
		start  = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				if (fire) begin
					start                    = 1'b1;
					st_nxt.activated_at      = item.now_seconds;
					st_nxt.last_fired_minute = item.now_minute;
					st_nxt.last_fired_valid  = 1'b1;
					// zero auto-mute silences in the same tick
					st_nxt.mode_state = (cfg.auto_mute_seconds == 16'd0) ?
						ST_ENABLED : ST_ACTIVE;
				end else if (st.mode_state == ST_ACTIVE) begin
					if (mute_due) begin
						st_nxt.mode_state = ST_ENABLED;
					end
				end else if (st.mode_state == ST_SNOOZED) begin
					if (!past_deadline[31]) begin
						start               = 1'b1;
						st_nxt.mode_state   = ST_ACTIVE;
						st_nxt.activated_at = item.now_seconds;
					end
				end
			end
			MODE_SET: begin
				st_nxt.alarm_hour   = item.set_hour;
				st_nxt.alarm_minute = item.set_minute;
				if (st.mode_state == ST_DISABLED) begin
					st_nxt.mode_state = ST_ENABLED;
				end
			end
			MODE_TOGGLE: begin
				st_nxt.mode_state = (st.mode_state == ST_DISABLED) ? ST_ENABLED : ST_DISABLED;
			end
			MODE_SNOOZE: begin
				if (st.mode_state == ST_ACTIVE) begin
					st_nxt.snooze_deadline = snooze_end;
					st_nxt.mode_state      = ST_SNOOZED;
				end
			end
			MODE_MUTE: begin
				if (st.mode_state == ST_ACTIVE || st.mode_state == ST_SNOOZED) begin
					st_nxt.mode_state = ST_ENABLED;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.alarm_state      = st_nxt.mode_state;
		res.buzzing          = (st_nxt.mode_state == ST_ACTIVE);
		res.buzzer_start     = start;
		res.alarm_hour_out   = st_nxt.alarm_hour;
		res.alarm_minute_out = st_nxt.alarm_minute;
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: alarm clock controller testbench
// Drives command items through a short table of corner cases, then long
// runs of random alarm scenarios under several duration settings, and
// checks every result item against its table row or an in-bench model of the alarm state.
// ----------------------------------------------------------------------------
module tb_top;
	import acc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 192;
	localparam int IDLE_PCT        = 38;
	localparam int HOLD_CYCLES     = 80;
	localparam int CMD_W           = $bits(cmd_item_t);

	localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
	localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
	localparam logic [15:0] PREDICTED     = 16'd0;

	typedef struct packed {
		cmd_item_t    it;
		logic         typed;
		result_item_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	acc_cmd_if    cmd_ch();
	acc_result_if res_ch();

	alarm_clock_controller_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	alarm_st_t    alarm_st;
	cfg_t         durations;
	result_item_t pending_results[$];
	int           mismatches;
	int           cycles;
	int           hold_left;
	bit           calm;
	bit           hold_req;

	stim_row_t opening_rows [27] = '{
		{MODE_TICK, 32'd0, 5'd0, 6'd0, 5'd0, 6'd0,
			1'b1, ST_DISABLED, 1'b0, 1'b0, 5'd0, 6'd0},
		{MODE_SPARE_LO, 32'hFFFF_FFFF, 5'd31, 6'd63, 5'd31, 6'd63,
			1'b1, ST_DISABLED, 1'b0, 1'b0, 5'd0, 6'd0},
		{MODE_SPARE_HI, 32'd0, 5'd0, 6'd0, 5'd0, 6'd0,
			1'b1, ST_DISABLED, 1'b0, 1'b0, 5'd0, 6'd0},
		{MODE_MUTE, 32'd5, 5'd0, 6'd0, 5'd0, 6'd0,
			1'b1, ST_DISABLED, 1'b0, 1'b0, 5'd0, 6'd0},
		{MODE_SET, 32'd10, 5'd0, 6'd0, 5'd7, 6'd30,
			1'b1, ST_ENABLED, 1'b0, 1'b0, 5'd7, 6'd30},
		{MODE_TICK, 32'd1000, 5'd7, 6'd30, 5'd0, 6'd0,
			1'b1, ST_ACTIVE, 1'b1, 1'b1, 5'd7, 6'd30},
		{MODE_TICK, 32'd1059, 5'd7, 6'd30, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'd1060, 5'd7, 6'd30, 5'd0, 6'd0, PREDICTED},
		{MODE_SNOOZE, 32'd1070, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_SET, 32'd1080, 5'd0, 6'd0, 5'd8, 6'd30, PREDICTED},
		{MODE_TICK, 32'd1100, 5'd8, 6'd30, 5'd0, 6'd0, PREDICTED},
		{MODE_SET, 32'd1110, 5'd0, 6'd0, 5'd31, 6'd63,
			1'b1, ST_ENABLED, 1'b0, 1'b0, 5'd31, 6'd63},
		{MODE_TICK, 32'hFFFF_FFF0, 5'd31, 6'd63, 5'd0, 6'd0,
			1'b1, ST_ACTIVE, 1'b1, 1'b1, 5'd31, 6'd63},
		{MODE_TICK, 32'h0000_002B, 5'd31, 6'd63, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'h0000_002C, 5'd31, 6'd63, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'h0000_002D, 5'd31, 6'd63, 5'd0, 6'd0, PREDICTED},
		{MODE_SET, 32'h0000_0030, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'hFFFF_FF00, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_SNOOZE, 32'hFFFF_FFFF, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'd0, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_TICK, 32'd299, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_SNOOZE, 32'd300, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_MUTE, 32'd301, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_SET, 32'd302, 5'd0, 6'd0, 5'd0, 6'd1, PREDICTED},
		{MODE_TICK, 32'd5000, 5'd0, 6'd1, 5'd0, 6'd0, PREDICTED},
		{MODE_TOGGLE, 32'd5001, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED},
		{MODE_TOGGLE, 32'd5002, 5'd0, 6'd0, 5'd0, 6'd0, PREDICTED}
	};

	cfg_t phase_cfg [PHASES] = '{
		{AUTO_MUTE_RST, SNOOZE_RST},
		{16'd0, 16'd7},
		{16'hFFFF, 16'hFFFF},
		{16'd12, 16'd0},
		{16'd3, 16'd40},
		{16'd0, 16'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_item_t alarm_next(input cmd_item_t it);
		result_item_t r;
		logic         fired;
		logic [31:0]  elapsed;
		logic [31:0]  past_deadline;

		fired = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				if (alarm_st.mode_state != ST_DISABLED) begin
					if (alarm_st.mode_state == ST_ENABLED &&
					    it.now_hour == alarm_st.alarm_hour &&
					    it.now_minute == alarm_st.alarm_minute &&
					    (!alarm_st.last_fired_valid ||
					     alarm_st.last_fired_minute != it.now_minute)) begin
						alarm_st.mode_state        = ST_ACTIVE;
						alarm_st.activated_at      = it.now_seconds;
						alarm_st.last_fired_minute = it.now_minute;
						alarm_st.last_fired_valid  = 1'b1;
						fired = 1'b1;
					end
					elapsed = it.now_seconds - alarm_st.activated_at;
					if (alarm_st.mode_state == ST_ACTIVE &&
					    elapsed >= {16'd0, durations.auto_mute_seconds})
						alarm_st.mode_state = ST_ENABLED;
					past_deadline = it.now_seconds - alarm_st.snooze_deadline;
					if (alarm_st.mode_state == ST_SNOOZED && !past_deadline[31]) begin
						alarm_st.mode_state   = ST_ACTIVE;
						alarm_st.activated_at = it.now_seconds;
						fired = 1'b1;
					end
				end
			end
			MODE_SET: begin
				alarm_st.alarm_hour   = it.set_hour;
				alarm_st.alarm_minute = it.set_minute;
				if (alarm_st.mode_state == ST_DISABLED)
					alarm_st.mode_state = ST_ENABLED;
			end
			MODE_TOGGLE: begin
				alarm_st.mode_state = (alarm_st.mode_state == ST_DISABLED) ?
					ST_ENABLED : ST_DISABLED;
			end
			MODE_SNOOZE: begin
				if (alarm_st.mode_state == ST_ACTIVE) begin
					alarm_st.snooze_deadline = it.now_seconds +
						{16'd0, durations.snooze_seconds};
					alarm_st.mode_state = ST_SNOOZED;
				end
			end
			MODE_MUTE: begin
				if (alarm_st.mode_state == ST_ACTIVE || alarm_st.mode_state == ST_SNOOZED)
					alarm_st.mode_state = ST_ENABLED;
			end
			default: ;
		endcase
		r.alarm_state      = alarm_st.mode_state;
		r.buzzing          = (alarm_st.mode_state == ST_ACTIVE);
		r.buzzer_start     = fired;
		r.alarm_hour_out   = alarm_st.alarm_hour;
		r.alarm_minute_out = alarm_st.alarm_minute;
		return r;
	endfunction

	task automatic offer(input cmd_item_t it, input logic typed, input result_item_t want);
		result_item_t predicted;

		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= it;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = alarm_next(it);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items outstanding", $time,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		res_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result item, expected none got %h", $time,
						res_ch.data);
					mismatches++;
				end else begin
					result_item_t want;
					want = pending_results.pop_front();
					check_field("alarm_state", 32'(want.alarm_state),
						32'(res_ch.data.alarm_state));
					check_field("buzzing", 32'(want.buzzing), 32'(res_ch.data.buzzing));
					check_field("buzzer_start", 32'(want.buzzer_start),
						32'(res_ch.data.buzzer_start));
					check_field("alarm_hour_out", 32'(want.alarm_hour_out),
						32'(res_ch.data.alarm_hour_out));
					check_field("alarm_minute_out", 32'(want.alarm_minute_out),
						32'(res_ch.data.alarm_minute_out));
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		cmd_item_t   it;
		cfg_t        c;
		logic [31:0] clock_s;
		logic [4:0]  pick_h;
		logic [5:0]  pick_m;
		int          r;
		int          span;

		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		hold_left    = 0;
		mismatches   = 0;
		cycles       = 0;
		alarm_st     = '0;
		durations    = {AUTO_MUTE_RST, SNOOZE_RST};
		clock_s      = 32'd0;
		pick_h       = 5'd0;
		pick_m       = 6'd0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) begin
			offer(opening_rows[i].it, opening_rows[i].typed, opening_rows[i].want);
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
			while (pending_results.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);

			c = phase_cfg[p];
			if (p == PHASES - 1) begin
				c.auto_mute_seconds = 16'($urandom_range(200));
				c.snooze_seconds    = 16'($urandom_range(400));
			end
			cfg_we    <= 1'b1;
			cfg_index <= CFG_AUTO_MUTE;
			cfg_wdata <= c.auto_mute_seconds;
			@(posedge clk);
			durations.auto_mute_seconds = c.auto_mute_seconds;
			cfg_index <= CFG_SNOOZE;
			cfg_wdata <= c.snooze_seconds;
			@(posedge clk);
			durations.snooze_seconds = c.snooze_seconds;
			cfg_we <= 1'b0;
			@(posedge clk);

			span = ((durations.auto_mute_seconds > durations.snooze_seconds) ?
				durations.auto_mute_seconds : durations.snooze_seconds) / 8 + 4;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				calm = (p == 1 && n < 150) || (p == 2 && n >= 20 && n < 120);
				if (p == 2 && n == 20)
					hold_req = 1'b1;
				if (p == 3 && n == 60) begin
					cmd_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending_results.size() != 0) @(posedge clk);
				end

				it = CMD_W'({$urandom, $urandom});
				r  = $urandom_range(99);
				if (r >= 6) begin
					it.now_seconds = clock_s;
					if (r < 14) begin
						it.mode = MODE_SET;
						pick_h  = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
						pick_m  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
						it.set_hour   = pick_h;
						it.set_minute = pick_m;
					end else if (r < 20) begin
						it.mode = MODE_TOGGLE;
					end else if (r < 30) begin
						it.mode = MODE_SNOOZE;
					end else if (r < 37) begin
						it.mode = MODE_MUTE;
					end else begin
						it.mode = MODE_TICK;
						if ($urandom_range(49) == 0)
							clock_s = $urandom;
						else
							clock_s = clock_s + $urandom_range(span);
						it.now_seconds = clock_s;
						r = $urandom_range(9);
						if (r < 6) begin
							it.now_hour   = pick_h;
							it.now_minute = pick_m;
						end else if (r < 8) begin
							it.now_hour   = pick_h;
							it.now_minute = 6'($urandom_range(59));
						end
					end
				end
				offer(it, 1'b0, '0);
				while (!calm && $urandom_range(99) < IDLE_PCT) begin
					cmd_ch.valid <= 1'b0;
					@(posedge clk);
				end
			end
		end

		calm = 1'b0;
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
